// File: rtl/sau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sau_pkg;

  // Interval count of the sigmoid table (257 knots); knots span [-8, 8].
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int TIDX_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int PROD_W        = 16 + IDX_W;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Operation codes (carried on tuser)
  localparam logic [2:0] OP_IDENT   = 3'd0;
  localparam logic [2:0] OP_D_IDENT = 3'd1;
  localparam logic [2:0] OP_UNI     = 3'd2;
  localparam logic [2:0] OP_D_UNI   = 3'd3;
  localparam logic [2:0] OP_BI      = 3'd4;
  localparam logic [2:0] OP_D_BI    = 3'd5;

  typedef logic [TABLE_ENTRIES:0][16:0] sig_tab_t;

  // Restoring long division, elaboration use only.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-a in Q30, a in Q30: series for a/256, then squared eight times.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] r3;
    logic [63:0] r4;
    logic [63:0] e;
    r  = a >> 8;
    r2 = (r * r) >> 30;
    r3 = (r2 * r) >> 30;
    r4 = (r3 * r) >> 30;
    e  = (64'd1 << 30) - r + r2 / 64'd2 - r3 / 64'd6 + r4 / 64'd24;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

  // Knot values in Q0.16, evaluated once at elaboration.
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    tab;
    logic [63:0] pos;
    logic [63:0] mid;
    logic [63:0] span;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] knot;
    logic        nonneg;
    mid = 64'(8 * TABLE_ENTRIES);
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      pos    = 64'(16 * i);
      nonneg = (pos >= mid);
      span   = nonneg ? (pos - mid) : (mid - pos);
      a      = udiv64(span << 30, 64'(TABLE_ENTRIES));
      e      = exp_neg_q30(a);
      d      = (64'd1 << 30) + e;
      num    = nonneg ? (64'd1 << 46) : (e << 16);
      knot   = udiv64(num + (d >> 1), d);
      tab[i] = knot[16:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

`default_nettype wire

// File: rtl/sigmoid_activation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one word per cycle when m_tready is not held low; seven pipeline
// stages with per-stage valids, and a bubble is squeezed out on an output stall.
// Reset (rst, synchronous, active high): clears all stage valids and loads
// beta with 1.0 (65536). No table init pass; the sigmoid table is constant.
module sigmoid_activation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // config: beta, Q1.16 steepness
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] x_in (signed Q4.12)
  input  wire logic [2:0]  s_tuser,   // [2:0] op
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [23:0] y_out (signed Q8.16)
);
  import sau_pkg::*;

  localparam int NSTG = 7;

  logic [16:0]     beta;
  logic [NSTG:1]   v;
  logic [NSTG:1]   rdy;

  // Stage 1: x * beta
  logic [2:0]         op_s1;
  logic signed [15:0] x_s1;
  logic signed [33:0] p_s1;

  // Stage 2: z = floor(p / 2^16), range check, table index and fraction
  logic [2:0]         op_s2;
  logic signed [15:0] x_s2;
  logic               sat_lo_s2;
  logic               sat_hi_s2;
  logic [IDX_W-1:0]   idx_s2;
  logic [15:0]        frac_s2;

  // Stage 3: table knots
  logic [2:0]         op_s3;
  logic signed [15:0] x_s3;
  logic               sat_lo_s3;
  logic               sat_hi_s3;
  logic [16:0]        t0_s3;
  logic [16:0]        t1_s3;
  logic [15:0]        frac_s3;

  // Stage 4: interpolated sigmoid s (Q0.16)
  logic [2:0]         op_s4;
  logic signed [15:0] x_s4;
  logic [16:0]        s_s4;

  // Stage 5: derivative product
  logic [2:0]         op_s5;
  logic signed [15:0] x_s5;
  logic [16:0]        s_s5;
  logic [33:0]        m_s5;

  // Stage 6: derivative before beta
  logic [2:0]         op_s6;
  logic signed [15:0] x_s6;
  logic [16:0]        s_s6;
  logic [16:0]        q_s6;

  // Stage 7: output register
  logic [23:0]        y_s7;

  // Combinational helpers
  logic signed [17:0]     z;
  logic [15:0]            u;
  logic [PROD_W-1:0]      uprod;
  logic signed [17:0]     delta;
  logic signed [34:0]     dprod;
  logic signed [34:0]     interp;
  logic signed [17:0]     b;
  logic [16:0]            b_abs;
  logic [16:0]            mul_a;
  logic [16:0]            mul_b;
  logic [33:0]            bb_sub;
  logic [33:0]            qb;
  logic signed [18:0]     bi_val;

  assign cfg_ready = 1'b1;
  assign s_tready  = rdy[1];
  assign m_tvalid  = v[NSTG];
  assign m_tdata   = y_s7;

  // A stage takes new data when empty or when the one after it moves.
  always_comb begin
    rdy[NSTG] = !v[NSTG] || m_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      beta <= ONE_Q16;
    end else begin
      if (cfg_valid && cfg_ready) begin
        beta <= cfg_data;
      end
      if (rdy[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 2 arithmetic: arithmetic shift gives floor for both signs.
  always_comb begin
    z     = 18'(p_s1 >>> 16);
    u     = z[15:0] ^ 16'h8000;
    uprod = PROD_W'(u) * PROD_W'(TABLE_ENTRIES);
  end

  // Stage 4 arithmetic: t0 + floor((t1 - t0) * frac / 2^16).
  always_comb begin
    delta  = $signed({1'b0, t1_s3}) - $signed({1'b0, t0_s3});
    dprod  = $signed({{17{delta[17]}}, delta}) * $signed({19'b0, frac_s3});
    interp = $signed({18'b0, t0_s3}) + (dprod >>> 16);
  end

  // Stage 5 operand select: s*(1-s) or b*b share one multiplier.
  always_comb begin
    b     = $signed({s_s4, 1'b0}) - $signed({1'b0, ONE_Q16});
    b_abs = b[17] ? 17'(-b) : 17'(b);
    if (op_s4 == OP_D_BI) begin
      mul_a = b_abs;
      mul_b = b_abs;
    end else begin
      mul_a = s_s4;
      mul_b = ONE_Q16 - s_s4;
    end
  end

  // Stage 6 / 7 arithmetic
  always_comb begin
    bb_sub = (34'd1 << 32) - m_s5;
    qb     = 34'(q_s6) * 34'(beta);
    bi_val = $signed({1'b0, s_s6, 1'b0}) - $signed({2'b0, ONE_Q16});
  end

  // Datapath registers, loaded whenever their stage moves.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op_s1 <= s_tuser;
      x_s1  <= $signed(s_tdata);
      p_s1  <= $signed({{18{s_tdata[15]}}, s_tdata}) * $signed({17'b0, beta});
    end
    if (rdy[2]) begin
      op_s2     <= op_s1;
      x_s2      <= x_s1;
      sat_lo_s2 <= (z < -18'sd32768);
      sat_hi_s2 <= (z >= 18'sd32768);
      idx_s2    <= uprod[PROD_W-1:16];
      frac_s2   <= uprod[15:0];
    end
    if (rdy[3]) begin
      op_s3     <= op_s2;
      x_s3      <= x_s2;
      sat_lo_s3 <= sat_lo_s2;
      sat_hi_s3 <= sat_hi_s2;
      t0_s3     <= SIG_TAB[TIDX_W'(idx_s2)];
      t1_s3     <= SIG_TAB[TIDX_W'(idx_s2) + TIDX_W'(1)];
      frac_s3   <= frac_s2;
    end
    if (rdy[4]) begin
      op_s4 <= op_s3;
      x_s4  <= x_s3;
      if (sat_lo_s3) begin
        s_s4 <= '0;
      end else if (sat_hi_s3) begin
        s_s4 <= ONE_Q16;
      end else begin
        s_s4 <= interp[16:0];
      end
    end
    if (rdy[5]) begin
      op_s5 <= op_s4;
      x_s5  <= x_s4;
      s_s5  <= s_s4;
      m_s5  <= 34'(mul_a) * 34'(mul_b);
    end
    if (rdy[6]) begin
      op_s6 <= op_s5;
      x_s6  <= x_s5;
      s_s6  <= s_s5;
      if (op_s5 == OP_D_BI) begin
        q_s6 <= 17'(bb_sub >> 16);
      end else begin
        q_s6 <= 17'(m_s5 >> 16);
      end
    end
    if (rdy[7]) begin
      case (op_s6)
        OP_IDENT:   y_s7 <= {{4{x_s6[15]}}, x_s6, 4'b0000};
        OP_D_IDENT: y_s7 <= 24'(ONE_Q16);
        OP_UNI:     y_s7 <= 24'(s_s6);
        OP_D_UNI:   y_s7 <= 24'(qb >> 16);
        OP_BI:      y_s7 <= {{5{bi_val[18]}}, bi_val};
        OP_D_BI:    y_s7 <= 24'(qb >> 17);
        default:    y_s7 <= '0;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Input can only be refused when every stage is full and the output stalls.
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> ((&v) && !m_tready))
    else $error("input stalled with a free pipeline stage");

  // An accepted word always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[1])
    else $error("accepted word lost at stage 1");

  // Saturation flags are exclusive.
  a_sat_excl: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> !(sat_lo_s3 && sat_hi_s3))
    else $error("both saturation flags set");

  // Sigmoid never exceeds 1.0.
  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    v[4] |-> (s_s4 <= ONE_Q16))
    else $error("sigmoid above 1.0");

  // s*(1-s) peaks at 0.25.
  a_duni_range: assert property (@(posedge clk) disable iff (rst)
    (v[6] && op_s6 == OP_D_UNI) |-> (q_s6 <= 17'd16384))
    else $error("unipolar derivative out of range");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sau_pkg::*;

  // Unused op codes; the block answers them with zero.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [16:0] BETA_MAX = 17'h1FFFF;
  localparam int DRAIN_CYCLES = 12;  // pipeline is 7 deep

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  sigmoid_activation_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  logic [2:0]  op_codes [8] = '{OP_IDENT, OP_D_IDENT, OP_UNI, OP_D_UNI,
                                OP_BI, OP_D_BI, OP_SPARE_A, OP_SPARE_B};
  longint      sig_knots [0:TABLE_ENTRIES];
  logic [16:0] beta_now;
  logic [23:0] y_pending [$];
  int          err_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          chunk_no = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // e^-a, a and result in Q30: short series on a/256, then squared 8 times
  function automatic longint exp_neg_fixed(input longint a);
    longint r;
    longint r2;
    longint r3;
    longint r4;
    longint e;
    r  = a >> 8;
    r2 = (r * r) >> 30;
    r3 = (r2 * r) >> 30;
    r4 = (r3 * r) >> 30;
    e  = (64'sd1 <<< 30) - r + r2 / 2 - r3 / 6 + r4 / 24;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'sd1 <<< 29)) >> 30;
    end
    return e;
  endfunction

  // Sigmoid knots in Q0.16 over [-8, 8]
  task automatic build_knots();
    longint mid;
    longint pos;
    longint span;
    longint e;
    longint d;
    longint num;
    mid = 8 * TABLE_ENTRIES;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      pos  = 16 * i;
      span = (pos >= mid) ? pos - mid : mid - pos;
      e    = exp_neg_fixed((span <<< 30) / TABLE_ENTRIES);
      d    = (64'sd1 <<< 30) + e;
      num  = (pos >= mid) ? (64'sd1 <<< 46) : (e <<< 16);
      sig_knots[i] = (num + d / 2) / d;
    end
  endtask

  // Expected y_out (Q8.16) for one word at steepness beta
  function automatic logic [23:0] calc_activation(input logic [2:0] op,
                                                  input logic signed [15:0] x,
                                                  input logic [16:0] beta);
    longint xv;
    longint bv;
    longint z;
    longint u;
    longint idx;
    longint frac;
    longint s;
    longint q;
    longint b;
    longint y;
    xv = x;
    bv = beta;
    z  = (xv * bv) >>> 16;  // floor toward -inf
    if (z < -32768) begin
      s = 0;
    end else if (z >= 32768) begin
      s = 65536;
    end else begin
      u    = (z + 32768) * TABLE_ENTRIES;
      idx  = u >> 16;
      frac = u & 65535;
      s    = (sig_knots[idx] * (65536 - frac) + sig_knots[idx + 1] * frac) >> 16;
    end
    case (op)
      OP_IDENT:   y = xv * 16;
      OP_D_IDENT: y = 65536;
      OP_UNI:     y = s;
      OP_D_UNI: begin
        q = (s * (65536 - s)) >> 16;
        y = (q * bv) >> 16;
      end
      OP_BI:      y = 2 * s - 65536;
      OP_D_BI: begin
        b = 2 * s - 65536;
        q = ((64'sd1 <<< 32) - b * b) >> 16;
        y = (q * bv) >> 17;
      end
      default:    y = 0;
    endcase
    return y[23:0];
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [15:0] x);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    y_pending.push_back(calc_activation(op, x, beta_now));
  endtask

  // Sender goes quiet until every expected word is back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (y_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_beta(input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    beta_now = value;
  endtask

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin : check_results
    logic [23:0] want_y;
    if (!rst && m_tvalid && m_tready) begin
      if (y_pending.size() == 0) begin
        $error("y_out: no result expected, got %h", m_tdata);
        err_count++;
      end else begin
        want_y = y_pending.pop_front();
        if (m_tdata !== want_y) begin
          $error("y_out mismatch: expected %h, actual %h", want_y, m_tdata);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Field extremes for every op code, sigmoid midpoint, rounding near zero
  task automatic test_directed_ops();
    for (int i = 0; i < 8; i++) begin
      send_word(op_codes[i], 16'h8000);
      send_word(op_codes[i], 16'h7FFF);
    end
    for (int i = 2; i < 6; i++) begin
      send_word(op_codes[i], 16'h0000);
    end
    send_word(OP_UNI, 16'hFFFF);
    send_word(OP_UNI, 16'h0001);
    wait_results_done();
  endtask

  function automatic logic [16:0] pick_beta();
    case (chunk_no)
      0:       return 17'd0;
      1:       return BETA_MAX;
      2:       return 17'd1;
      3:       return ONE_Q16;
      default: begin
        if ($urandom_range(1) == 0) return 17'($urandom_range(1, 65536));
        return 17'($urandom_range(0, 131071));
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_x();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(0, 4095) - 2048);
      1:       return $urandom_range(1) ? 16'(32767 - $urandom_range(511))
                                        : 16'(-32768 + $urandom_range(511));
      default: return 16'($urandom());
    endcase
  endfunction

  // Random words in chunks, each chunk at its own beta, with a full
  // pause halfway through every chunk
  task automatic test_stream(input int tx_pct, input int rx_pct);
    logic [2:0] op;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int c = 0; c < 4; c++) begin
      wait_results_done();
      write_beta(pick_beta());
      chunk_no++;
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(99) < 5) op = op_codes[6 + $urandom_range(1)];
        else op = op_codes[$urandom_range(5)];
        send_word(op, pick_x());
        if (n == 60) wait_results_done();
      end
    end
    wait_results_done();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    beta_now = ONE_Q16;
    build_knots();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 8;
    rx_idle_pct = 73;
    test_directed_ops();
    test_stream(8, 73);
    test_stream(73, 8);
    test_stream(0, 0);

    wait_results_done();
    if (err_count == 0 && y_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
